@@ src/gri_pkg.sv @@
// Shared types and constants for the gyro rate integrator.
`timescale 1ns / 1ps
`default_nettype none
package gri_pkg;

	localparam int RAW_W       = 16;
	localparam int TICK_W      = 16;
	localparam int DZ_W        = 15;
	localparam int ANGLE_OUT_W = 16;
	localparam int NUM_AXES    = 3;
	localparam int AXIS_W      = 2;

	localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

	// status bit that marks fresh sensor data
	localparam int STATUS_NEW_BIT = 3;

	localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = 15'd5;

	// two-entry queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef struct packed {
		logic                          sample_taken;
		logic                          divide_error;
		logic signed [ANGLE_OUT_W-1:0] x_angle;
		logic signed [ANGLE_OUT_W-1:0] y_angle;
		logic signed [ANGLE_OUT_W-1:0] z_angle;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

@@ src/gri_queue.sv @@
// Two-entry item queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module gri_queue #(
	parameter int W = 53
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [W-1:0]        wr_data,
	input  wire logic                rd_en,
	output logic [W-1:0]             rd_data,
	output gri_pkg::q_status_t       status
);

	logic [W-1:0]                    mem_q [gri_pkg::Q_DEPTH];
	logic [gri_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [gri_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [gri_pkg::Q_CNT_W-1:0]     cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign status.full  = (cnt_q == gri_pkg::Q_CNT_W'(gri_pkg::Q_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/gri_front.sv @@
// Front end: takes items, classifies them and forms rate sums and tick deltas.
`timescale 1ns / 1ps
`default_nettype none
module gri_front #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int EW           = 2 + 16 + 3 * (SAMPLE_WIDTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [7:0]                   status_byte,
	input  wire logic [gri_pkg::RAW_W-1:0]    x_raw,
	input  wire logic [gri_pkg::RAW_W-1:0]    y_raw,
	input  wire logic [gri_pkg::RAW_W-1:0]    z_raw,
	input  wire logic [gri_pkg::TICK_W-1:0]   tick_now,
	input  wire gri_pkg::q_status_t           q_status,
	output logic                              q_push,
	output logic [EW-1:0]                     q_data
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int SUM_W = SW + 1;
	localparam int RW    = (SW > gri_pkg::RAW_W) ? SW : gri_pkg::RAW_W;

	logic [gri_pkg::RAW_W-1:0]  raw      [gri_pkg::NUM_AXES];
	logic [SW-1:0]              rate     [gri_pkg::NUM_AXES];
	logic [SUM_W-1:0]           rsum     [gri_pkg::NUM_AXES];
	logic [SW-1:0]              last_rate_q [gri_pkg::NUM_AXES];
	logic [gri_pkg::TICK_W-1:0] last_tick_q;
	logic [gri_pkg::TICK_W-1:0] diff;
	logic                       taken;
	logic                       err;

	assign raw[0] = x_raw;
	assign raw[1] = y_raw;
	assign raw[2] = z_raw;

	assign full   = q_status.full;
	assign q_push = push && !q_status.full;
	assign taken  = status_byte[gri_pkg::STATUS_NEW_BIT];
	assign diff   = tick_now - last_tick_q;
	assign err    = taken && (diff == '0);

	for (genvar i = 0; i < gri_pkg::NUM_AXES; i++) begin : g_axis
		logic signed [RW-1:0] raw_ext;
		assign raw_ext = RW'($signed(raw[i]));
		// negate at sample width; the most negative word wraps to itself
		assign rate[i] = SW'(~raw_ext[SW-1:0] + 1'b1);
		assign rsum[i] = {rate[i][SW-1], rate[i]} + {last_rate_q[i][SW-1], last_rate_q[i]};
		assign q_data[SUM_W*i +: SUM_W] = rsum[i];
	end

	assign q_data[EW-1 -: 2 + gri_pkg::TICK_W] = {taken, err, diff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q <= '0;
			for (int i = 0; i < gri_pkg::NUM_AXES; i++) begin
				last_rate_q[i] <= '0;
			end
		end else if (q_push && taken) begin
			last_tick_q <= tick_now;
			for (int i = 0; i < gri_pkg::NUM_AXES; i++) begin
				last_rate_q[i] <= rate[i];
			end
		end
	end

endmodule
`default_nettype wire

@@ src/gri_back.sv @@
// Back end: shared radix-4 divider, dead-zone test, angle accumulation, result register.
`timescale 1ns / 1ps
`default_nettype none
module gri_back #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int EW           = 2 + 16 + 3 * (SAMPLE_WIDTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     dead_zone_we,
	input  wire logic [gri_pkg::DZ_W-1:0] dead_zone_wdata,
	input  wire gri_pkg::q_status_t       q_status,
	input  wire logic [EW-1:0]            q_data,
	output logic                          q_pop,
	output gri_pkg::res_t                 res,
	output logic                          res_valid,
	input  wire logic                     res_pop
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int SUM_W  = SW + 1;
	localparam int NB     = SUM_W + (SUM_W % 2);
	localparam int STEPS  = NB / 2;
	localparam int CNT_W  = $clog2(STEPS);
	localparam int CW     = (NB > gri_pkg::DZ_W) ? NB : gri_pkg::DZ_W;
	localparam int AW     = (SW > gri_pkg::ANGLE_OUT_W) ? SW : gri_pkg::ANGLE_OUT_W;
	localparam int TW     = gri_pkg::TICK_W;

	localparam logic [NB-1:0]    HI_MAG   = NB'((64'd1 << (SW - 1)) - 64'd1);
	localparam logic [NB-1:0]    LO_MAG   = NB'(64'd1 << (SW - 1));
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                  state_q;
	logic [gri_pkg::AXIS_W-1:0]  axis_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        taken_q;
	logic                        err_q;
	logic [TW-1:0]               diff_q;
	logic [SUM_W-1:0]            sum_q   [gri_pkg::NUM_AXES];
	logic [SW-1:0]               angle_q [gri_pkg::NUM_AXES];
	logic [gri_pkg::DZ_W-1:0]    dead_zone_q;
	logic [NB-1:0]               dvd_q;
	logic [NB-1:0]               quo_q;
	logic [TW-1:0]               rem_q;
	logic                        neg_q;
	logic                        res_valid_q;
	gri_pkg::res_t               res_q;
	logic                        slot_free;

	// load
	logic [SUM_W-1:0]            sum_sel;
	logic [SUM_W-1:0]            sum_mag;

	// two restoring steps per cycle
	logic [TW:0]                 r1;
	logic                        b1;
	logic [TW-1:0]               r1n;
	logic [TW:0]                 r2;
	logic                        b2;
	logic [TW-1:0]               r2n;

	// accumulate
	logic [NB-1:0]               lim;
	logic [NB-1:0]               inc_mag;
	logic [SW-1:0]               inc;
	logic                        over_dz;

	logic [gri_pkg::ANGLE_OUT_W-1:0] ang_out [gri_pkg::NUM_AXES];

	assign slot_free = !res_valid_q || res_pop;
	assign q_pop     = (state_q == ST_IDLE) && !q_status.empty;
	assign res       = res_q;
	assign res_valid = res_valid_q;

	assign sum_sel = sum_q[axis_q];
	assign sum_mag = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;

	assign r1  = {rem_q, dvd_q[NB-1]};
	assign b1  = (r1 >= {1'b0, diff_q});
	assign r1n = b1 ? TW'(r1 - {1'b0, diff_q}) : TW'(r1);
	assign r2  = {r1n, dvd_q[NB-2]};
	assign b2  = (r2 >= {1'b0, diff_q});
	assign r2n = b2 ? TW'(r2 - {1'b0, diff_q}) : TW'(r2);

	// saturate the quotient magnitude to the signed sample range
	assign lim     = neg_q ? LO_MAG : HI_MAG;
	assign inc_mag = (quo_q > lim) ? lim : quo_q;
	assign inc     = neg_q ? SW'(~inc_mag[SW-1:0] + 1'b1) : inc_mag[SW-1:0];
	assign over_dz = CW'(inc_mag) > CW'(dead_zone_q);

	for (genvar i = 0; i < gri_pkg::NUM_AXES; i++) begin : g_out
		logic signed [AW-1:0] ang_ext;
		assign ang_ext    = AW'($signed(angle_q[i]));
		assign ang_out[i] = ang_ext[gri_pkg::ANGLE_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= gri_pkg::DEAD_ZONE_RESET;
		end else if (dead_zone_we) begin
			dead_zone_q <= dead_zone_wdata;
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					{taken_q, err_q, diff_q} <= q_data[EW-1 -: 2 + TW];
					for (int i = 0; i < gri_pkg::NUM_AXES; i++) begin
						sum_q[i] <= q_data[SUM_W*i +: SUM_W];
					end
				end
			end
			ST_LOAD: begin
				dvd_q <= NB'(sum_mag);
				quo_q <= '0;
				rem_q <= '0;
				neg_q <= sum_sel[SUM_W-1];
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[NB-3:0], 2'b00};
				quo_q <= {quo_q[NB-3:0], b1, b2};
				rem_q <= r2n;
			end
			ST_DONE: begin
				if (slot_free) begin
					res_q.sample_taken <= taken_q;
					res_q.divide_error <= err_q;
					res_q.x_angle      <= ang_out[0];
					res_q.y_angle      <= ang_out[1];
					res_q.z_angle      <= ang_out[2];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= gri_pkg::AXIS_FIRST;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < gri_pkg::NUM_AXES; i++) begin
				angle_q[i] <= '0;
			end
		end else begin
			// a pop while the next result is ready is handled in ST_DONE
			if (res_pop && res_valid_q && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						axis_q <= gri_pkg::AXIS_FIRST;
						// busy and zero-tick items skip the divider
						if (q_data[EW-1] && !q_data[EW-2]) begin
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (over_dz) begin
						angle_q[axis_q] <= angle_q[axis_q] + inc;
					end
					if (axis_q == gri_pkg::AXIS_LAST) begin
						state_q <= ST_DONE;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/gyro_rate_integrator.sv @@
// Top level of the gyro rate integrator: front end, item queue and back end.
//
//  channel   | handshake         | payload
//  ----------+-------------------+---------------------------------------------------
//  input     | push / full       | status_byte, x_raw, y_raw, z_raw, tick_now
//  result    | pop / empty       | sample_taken, divide_error, x_angle, y_angle, z_angle
//  config    | dead_zone_we      | dead_zone_wdata
//
// A sample item passes through ST_IDLE, then ST_LOAD, ST_DIV and ST_ACC for each of the
// three axes in turn, then ST_DONE; the shared divider resolves two quotient bits a cycle
// in ST_DIV over NB bits, NB being SAMPLE_WIDTH + 1 rounded up to even.
// Busy and zero-tick items go from ST_IDLE straight to ST_DONE.
// A two-entry queue lets the front take items while the back works or a result waits.
// arst_n clears angles, previous rates and tick, and loads dead_zone with 5.
`timescale 1ns / 1ps
`default_nettype none
module gyro_rate_integrator #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [7:0]          status_byte,
	input  wire logic [15:0]         x_raw,
	input  wire logic [15:0]         y_raw,
	input  wire logic [15:0]         z_raw,
	input  wire logic [15:0]         tick_now,
	output logic                     empty,
	input  wire logic                pop,
	output logic                     sample_taken,
	output logic                     divide_error,
	output logic signed [15:0]       x_angle,
	output logic signed [15:0]       y_angle,
	output logic signed [15:0]       z_angle,
	input  wire logic                dead_zone_we,
	input  wire logic [14:0]         dead_zone_wdata
);

	localparam int EW = 2 + gri_pkg::TICK_W + gri_pkg::NUM_AXES * (SAMPLE_WIDTH + 1);

	gri_pkg::q_status_t q_status;
	gri_pkg::res_t      res;
	logic               q_push;
	logic               q_pop;
	logic [EW-1:0]      q_wdata;
	logic [EW-1:0]      q_rdata;
	logic               res_valid;

	gri_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.EW           (EW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.status_byte  (status_byte),
		.x_raw        (x_raw),
		.y_raw        (y_raw),
		.z_raw        (z_raw),
		.tick_now     (tick_now),
		.q_status     (q_status),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	gri_queue #(
		.W       (EW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.status  (q_status)
	);

	gri_back #(
		.SAMPLE_WIDTH    (SAMPLE_WIDTH),
		.EW              (EW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.dead_zone_we    (dead_zone_we),
		.dead_zone_wdata (dead_zone_wdata),
		.q_status        (q_status),
		.q_data          (q_rdata),
		.q_pop           (q_pop),
		.res             (res),
		.res_valid       (res_valid),
		.res_pop         (pop)
	);

	assign empty        = !res_valid;
	assign sample_taken = res.sample_taken;
	assign divide_error = res.divide_error;
	assign x_angle      = res.x_angle;
	assign y_angle      = res.y_angle;
	assign z_angle      = res.z_angle;

	a_err_implies_taken: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (sample_taken || !divide_error))
		else $error("divide error flagged on a result without a sample");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("back end took an item from an empty queue");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("front end wrote into a full queue");

	a_result_enters_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !q_status.empty) |=> (q_pop || $past(q_pop) || !q_status.empty || empty))
		else $error("result slot or queue lost track of an item");

endmodule
`default_nettype wire
